// ===== src/swes_pkg.sv =====
// Package with shared types and constants for the sliding window energy statistics unit.
`default_nettype none
package swes_pkg;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 32;
    localparam int ENERGY_W = 39;
    localparam int LEN_W    = 9;
    localparam int SUM_W    = 26;
    localparam int OUT_DATA_W = 152;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_BEST   = 1'b1;

    typedef struct packed {
        logic                       found;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [ENERGY_W-1:0]        energy;
        logic [INDEX_W-1:0]         end_index;
        logic [INDEX_W-1:0]         start_index;
    } result_t;
endpackage
`default_nettype wire

// ===== src/sliding_window_energy_stats_unit.sv =====
// Top level of the sliding window energy statistics unit.
// Flow: an accepted word is written to the ring, then the window is scanned one
// entry per cycle walking backwards, then a restoring divide forms the mean.
// Throughput: one sample at a time; the next word is taken once the results are handed over.
// Reset: rst_n clears FSM, counters and best record, sets window length 16; ring contents undefined.
`default_nettype none
module sliding_window_energy_stats_unit #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [swes_pkg::LEN_W-1:0] cfg_data,       // window_len
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,                       // sample
    input  wire logic        s_tlast,                       // end_of_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // start_index, end_index, energy, mean_value, min_value, max_value, found (low to high)
    output logic [swes_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic             m_tuser,                       // kind
    output logic             m_tlast                        // last
);
    import swes_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SCAN, S_DIV, S_OUT_WIN, S_OUT_BEST
    } state_t;

    // The ring of the last samples, one write and one registered read port.
    logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;

    state_t               state_reg;
    logic [LEN_W-1:0]     wlen_reg;
    logic [AW-1:0]        wpos_reg;
    logic [INDEX_W-1:0]   count_reg;
    logic [CW-1:0]        fill_reg;
    logic [ENERGY_W-1:0]  best_energy_reg;
    logic [INDEX_W-1:0]   best_start_reg, best_end_reg;
    logic                 have_best_reg;
    logic                 eos_reg;

    // Scan state.
    logic [CW-1:0]              len_reg;     // effective window length
    logic [CW-1:0]              left_reg;    // reads still to issue
    logic [CW-1:0]              got_reg;     // data words still to arrive
    logic [AW-1:0]              raddr_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [ENERGY_W-1:0]        en_reg;
    logic signed [SAMPLE_W-1:0] min_reg, max_reg;
    logic [INDEX_W-1:0]         idx_reg;

    // Divider state: magnitude of the sum divided by the length.
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [4:0]        div_cnt_reg;
    logic              neg_reg;

    result_t out_reg;
    logic    kind_reg, last_reg, mvalid_reg;

    // Effective window length: 0 acts as 1, larger than the ring acts as the ring size.
    logic [CW-1:0] eff_len;
    always_comb
    begin
        if (wlen_reg == '0)
            eff_len = CW'(1);
        else if (32'(wlen_reg) > WINDOW_MAX)
            eff_len = CW'(WINDOW_MAX);
        else
            eff_len = CW'(wlen_reg);
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !s_tvalid;
    assign wr_en     = s_tvalid && s_tready;
    assign rd_addr   = raddr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wpos_reg] <= s_tdata;
        rd_data_reg <= ring_mem[rd_addr];
    end

    logic signed [SAMPLE_W-1:0] s_val;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic [SUM_W-1:0] rem_sh;
    logic [SUM_W-1:0] sum_mag;
    assign s_val   = signed'(rd_data_reg);
    assign sq      = s_val * s_val;
    assign rem_sh  = {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wlen_reg        <= LEN_W'(16);
            wpos_reg        <= '0;
            count_reg       <= '0;
            fill_reg        <= '0;
            best_energy_reg <= '0;
            best_start_reg  <= '0;
            best_end_reg    <= '0;
            have_best_reg   <= 1'b0;
            mvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                wlen_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (wr_en)
                    begin
                        eos_reg    <= s_tlast;
                        idx_reg    <= count_reg;
                        len_reg    <= eff_len;
                        wpos_reg   <= (32'(wpos_reg) == WINDOW_MAX - 1) ? '0 : wpos_reg + 1'b1;
                        count_reg  <= count_reg + 1'b1;
                        if (32'(fill_reg) < WINDOW_MAX)
                            fill_reg <= fill_reg + 1'b1;
                        raddr_reg  <= wpos_reg;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    // New sample is in the ring; scan a full window, else go idle or end the stream.
                    if (fill_reg >= len_reg)
                    begin
                        left_reg  <= len_reg;
                        got_reg   <= len_reg;
                        sum_reg   <= '0;
                        en_reg    <= '0;
                        min_reg   <= 16'sh7FFF;
                        max_reg   <= 16'sh8000;
                        state_reg <= S_SCAN;
                    end
                    else if (eos_reg)
                        state_reg <= S_OUT_BEST;
                    else
                        state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // One read issued per cycle walking backwards; data returns through rd_data_reg.
                    if (left_reg != '0)
                    begin
                        left_reg  <= left_reg - 1'b1;
                        raddr_reg <= (raddr_reg == '0) ? AW'(WINDOW_MAX - 1) : raddr_reg - 1'b1;
                    end
                    if (left_reg != len_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(s_val);
                        en_reg  <= en_reg + ENERGY_W'(unsigned'(sq));
                        if (s_val < min_reg) min_reg <= s_val;
                        if (s_val > max_reg) max_reg <= s_val;
                        got_reg <= got_reg - 1'b1;
                        if (got_reg == CW'(1))
                            state_reg <= S_DIV;
                    end
                    div_cnt_reg <= '0;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == 5'd0)
                    begin
                        neg_reg     <= sum_reg[SUM_W-1];
                        quo_reg     <= sum_mag;
                        rem_reg     <= '0;
                        div_cnt_reg <= 5'd1;
                        if (!have_best_reg || en_reg > best_energy_reg)
                        begin
                            have_best_reg   <= 1'b1;
                            best_energy_reg <= en_reg;
                            best_start_reg  <= idx_reg - INDEX_W'(len_reg - 1'b1);
                            best_end_reg    <= idx_reg;
                        end
                    end
                    else if (div_cnt_reg <= 5'(SUM_W))
                    begin
                        if (rem_sh >= SUM_W'(len_reg))
                        begin
                            rem_reg <= rem_sh - SUM_W'(len_reg);
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        out_reg.start_index <= idx_reg - INDEX_W'(len_reg - 1'b1);
                        out_reg.end_index   <= idx_reg;
                        out_reg.energy      <= en_reg;
                        out_reg.mean_value  <= neg_reg ? SAMPLE_W'(-quo_reg)
                                                       : SAMPLE_W'(quo_reg);
                        out_reg.min_value   <= min_reg;
                        out_reg.max_value   <= max_reg;
                        out_reg.found       <= 1'b0;
                        kind_reg            <= KIND_WINDOW;
                        last_reg            <= !eos_reg;
                        mvalid_reg          <= 1'b1;
                        state_reg           <= S_OUT_WIN;
                    end
                end
                S_OUT_WIN:
                begin
                    if (m_tready)
                    begin
                        mvalid_reg <= 1'b0;
                        state_reg  <= eos_reg ? S_OUT_BEST : S_IDLE;
                    end
                end
                S_OUT_BEST:
                begin
                    if (!mvalid_reg)
                    begin
                        out_reg.start_index <= have_best_reg ? best_start_reg : '0;
                        out_reg.end_index   <= have_best_reg ? best_end_reg : '0;
                        out_reg.energy      <= have_best_reg ? best_energy_reg : '0;
                        out_reg.mean_value  <= '0;
                        out_reg.min_value   <= '0;
                        out_reg.max_value   <= '0;
                        out_reg.found       <= have_best_reg;
                        kind_reg            <= KIND_BEST;
                        last_reg            <= 1'b1;
                        mvalid_reg          <= 1'b1;
                    end
                    else if (m_tready)
                    begin
                        // Stream ends: clear for the next one, window length is kept.
                        mvalid_reg      <= 1'b0;
                        wpos_reg        <= '0;
                        count_reg       <= '0;
                        fill_reg        <= '0;
                        best_energy_reg <= '0;
                        best_start_reg  <= '0;
                        best_end_reg    <= '0;
                        have_best_reg   <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_DATA_W'({out_reg.found, out_reg.max_value, out_reg.min_value,
                                   out_reg.mean_value, out_reg.energy, out_reg.end_index,
                                   out_reg.start_index});
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // Input is only taken while no result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !mvalid_reg)
        else $error("input accepted while a result is pending");
    // A best result always closes the run of results of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && kind_reg == KIND_BEST) |-> last_reg)
        else $error("best result not marked last");
    // During the scan, the data words still to arrive are never fewer than the reads still to issue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (got_reg >= left_reg))
        else $error("scan counters out of order");
endmodule
`default_nettype wire
